@@ hdl/pel_pkg.sv @@
package pel_pkg;

  // grid size
  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;
  localparam int CELLS  = SIZE_X * SIZE_Y * SIZE_Z;

  // walk counter and address widths
  localparam int XW     = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
  localparam int YW     = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
  localparam int ZW     = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // field and register widths
  localparam int COORD_IN_W = 4;
  localparam int POT_W      = 16;
  localparam int LEAD_W     = 14;
  localparam int SCALE_W    = 32;
  localparam int DIMS_W     = 2;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int R_W       = LEAD_W + 1;
  localparam int R2_W      = 2 * R_W;
  localparam int SQ_FRAC   = 32;
  localparam int SQ_IN_W   = R2_W + SQ_FRAC;
  localparam int SQ_STEPS  = SQ_IN_W / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int D_W       = R2_W + ROOT_W;
  localparam int WSHIFT    = 40;
  localparam int NUM_W     = D_W + 1;
  localparam int Q_W       = 25;
  localparam int DIFF_W    = POT_W + 1;
  localparam int TERM_W    = DIFF_W + Q_W + 1;
  localparam int ACC_W     = 64;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 3'd0,
    REG_LEAD_X = 3'd1,
    REG_LEAD_Y = 3'd2,
    REG_LEAD_Z = 3'd3,
    REG_DIMS   = 3'd4
  } cfg_reg_e;

endpackage

@@ hdl/pel_sqrt.sv @@
module pel_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pel_pkg::SQ_IN_W-1:0]  radicand_i,
  output logic                         done_o,
  output logic [pel_pkg::ROOT_W-1:0]   root_o
);
  import pel_pkg::*;

  localparam int CNT_W = $clog2(SQ_STEPS);

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SQ_IN_W-1:0] rem_q, rem_d;
  logic [SQ_IN_W-1:0] res_q, res_d;
  logic [SQ_IN_W-1:0] bit_q, bit_d;
  logic [SQ_IN_W-1:0] trial;
  logic               last;

  assign trial  = res_q + bit_q;
  assign last   = (cnt_q == CNT_W'(SQ_STEPS - 1));
  assign done_o = busy_q && last;
  assign root_o = res_q[ROOT_W-1:0];

  // one result bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = radicand_i;
      res_d  = '0;
      bit_d  = SQ_IN_W'(1) << (2 * SQ_STEPS - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

endmodule

@@ hdl/pel_div.sv @@
module pel_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pel_pkg::NUM_W-1:0]  num_i,
  input  logic [pel_pkg::D_W-1:0]    den_i,
  output logic                       done_o,
  output logic [pel_pkg::Q_W-1:0]    quot_o
);
  import pel_pkg::*;

  localparam int CNT_W = $clog2(Q_W);
  localparam int DSH_W = D_W + Q_W - 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0] dsh_q, dsh_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic             fits;
  logic             last;

  assign fits   = DSH_W'(rem_q) >= dsh_q;
  assign last   = (cnt_q == CNT_W'(Q_W - 1));
  assign done_o = busy_q && last;
  assign quot_o = quot_q;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      dsh_d  = DSH_W'(den_i) << (Q_W - 1);
      quot_d = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q[NUM_W-1:0];
      end
      quot_d = {quot_q[Q_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

endmodule

@@ hdl/pseudo_ecg_lead_sum_top.sv @@
// load word: written to the cell memory when its coordinates are in range, no result
// compute word: walks every grid cell; a tissue cell with active axes sums three squares, takes a
// 31-step square root and forms r cubed, then each usable axis runs the 25-step divider and adds
// its term; after the last cell the sum is scaled, saturated and emitted
// one word is in flight at a time; ready is low from the start of a grid walk until its result is emitted
// after reset a clearing pass writes zero to all 4096 cells of the tissue map; configuration taken always
module pseudo_ecg_lead_sum_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [pel_pkg::COORD_IN_W-1:0]   cell_x_i,
  input  logic [pel_pkg::COORD_IN_W-1:0]   cell_y_i,
  input  logic [pel_pkg::COORD_IN_W-1:0]   cell_z_i,
  input  logic signed [pel_pkg::POT_W-1:0] potential_i,
  input  logic                             tissue_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [pel_pkg::OUT_W-1:0] ecg_value_o,
  input  logic                             cfg_we_i,
  input  logic [pel_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pel_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pel_pkg::*;

  typedef enum logic [17:0] {
    S_CLEAR = 18'b000000000000000001,
    S_IDLE  = 18'b000000000000000010,
    S_CTR   = 18'b000000000000000100,
    S_CTRW  = 18'b000000000000001000,
    S_SQ    = 18'b000000000000010000,
    S_SQS   = 18'b000000000000100000,
    S_SQW   = 18'b000000000001000000,
    S_DMUL  = 18'b000000000010000000,
    S_NRD1  = 18'b000000000100000000,
    S_NRD2  = 18'b000000001000000000,
    S_NCHK  = 18'b000000010000000000,
    S_DVS   = 18'b000000100000000000,
    S_DVW   = 18'b000001000000000000,
    S_TERM  = 18'b000010000000000000,
    S_ACC   = 18'b000100000000000000,
    S_SC1   = 18'b001000000000000000,
    S_SC2   = 18'b010000000000000000,
    S_DONE  = 18'b100000000000000000
  } state_e;

  localparam int MEM_W = POT_W + 1;
  localparam logic [OUT_W:0] POS_MAX = {2'b00, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W:0] NEG_MAG = {2'b01, {(OUT_W - 1){1'b0}}};

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic [XW-1:0]            x_q, x_d;
  logic [YW-1:0]            y_q, y_d;
  logic [ZW-1:0]            z_q, z_d;
  logic [1:0]               sq_q, sq_d;
  logic [1:0]               ax_q, ax_d;
  logic [R2_W-1:0]          r2_q, r2_d;
  logic [D_W-1:0]           d_q, d_d;
  logic [MEM_W-1:0]         pp_q, pp_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [TERM_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]         plo_q, plo_d;
  logic [ACC_W:0]           v_q, v_d;
  logic                     out_valid_q, out_valid_d;
  logic [OUT_W-1:0]         out_q, out_d;

  logic [SCALE_W-1:0]       scale_q;
  logic [LEAD_W-1:0]        lead_x_q, lead_y_q, lead_z_q;
  logic [DIMS_W-1:0]        dims_q;

  // cell memory: tissue flag over potential
  logic [MEM_W-1:0]         mem [CELLS];
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [MEM_W-1:0]         mem_wdata, rdata_q;

  logic                     sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]        root;
  logic                     div_start, div_done;
  logic [Q_W-1:0]           quot;
  logic [NUM_W-1:0]         num;

  logic signed [R_W-1:0]    rx, ry, rz, rsel, ra;
  logic signed [R2_W-1:0]   sq_prod;
  logic                     ra_neg;
  logic [R_W-2:0]           ra_mag;
  logic signed [Q_W:0]      w;
  logic [ADDR_W-1:0]        stride;
  logic                     plus_ok, minus_ok;
  logic                     last_axis, last_cell;
  logic                     load_ok;
  logic [ADDR_W-1:0]        load_addr;
  logic [ACC_W-1:0]         mag;
  logic [OUT_W:0]           v_cut;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ecg_value_o = $signed(out_q);

  // lead offsets
  assign rx = $signed({1'b0, LEAD_W'(x_q)}) - $signed({1'b0, lead_x_q});
  assign ry = $signed({1'b0, LEAD_W'(y_q)}) - $signed({1'b0, lead_y_q});
  assign rz = $signed({1'b0, LEAD_W'(z_q)}) - $signed({1'b0, lead_z_q});

  always_comb begin
    case (sq_q)
      2'd0:    rsel = rx;
      2'd1:    rsel = ry;
      default: rsel = rz;
    endcase
  end
  assign sq_prod = rsel * rsel;

  // per-axis selection
  always_comb begin
    case (ax_q)
      2'd0: begin
        ra       = rx;
        stride   = ADDR_W'(SIZE_Y * SIZE_Z);
        plus_ok  = (32'(x_q) != SIZE_X - 1);
        minus_ok = (x_q != '0);
      end
      2'd1: begin
        ra       = ry;
        stride   = ADDR_W'(SIZE_Z);
        plus_ok  = (32'(y_q) != SIZE_Y - 1);
        minus_ok = (y_q != '0);
      end
      default: begin
        ra       = rz;
        stride   = ADDR_W'(1);
        plus_ok  = (32'(z_q) != SIZE_Z - 1);
        minus_ok = (z_q != '0);
      end
    endcase
  end

  assign ra_neg = ra[R_W-1];
  assign ra_mag = ra_neg ? (R_W - 1)'(-ra) : (R_W - 1)'(ra);
  assign num    = NUM_W'({ra_mag, {WSHIFT{1'b0}}}) + NUM_W'(d_q >> 1);
  assign w      = ra_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign last_axis = ({1'b0, ax_q} + 3'd1) >= {1'b0, dims_q};
  assign last_cell = (32'(idx_q) == CELLS - 1);

  // load address
  assign load_ok   = (32'(cell_x_i) < SIZE_X) && (32'(cell_y_i) < SIZE_Y) &&
                     (32'(cell_z_i) < SIZE_Z);
  assign load_addr = ADDR_W'(32'(cell_x_i) * (SIZE_Y * SIZE_Z) +
                             32'(cell_y_i) * SIZE_Z + 32'(cell_z_i));

  // output magnitude
  assign mag   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign v_cut = v_q[OUT_W:0];

  assign sqrt_start = (state_q == S_SQS);
  assign div_start  = (state_q == S_DVS);

  pel_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({r2_q, {SQ_FRAC{1'b0}}}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  pel_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (d_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    sq_d        = sq_q;
    ax_d        = ax_q;
    r2_d        = r2_q;
    d_d         = d_q;
    pp_d        = pp_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    plo_d       = plo_q;
    v_d         = v_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_raddr   = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + ADDR_W'(1);
        if (last_cell) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            acc_d   = '0;
            idx_d   = '0;
            x_d     = '0;
            y_d     = '0;
            z_d     = '0;
            state_d = S_CTR;
          end else begin
            mem_we    = load_ok;
            mem_waddr = load_addr;
            mem_wdata = {tissue_i, potential_i};
          end
        end
      end
      S_CTR: begin
        state_d = S_CTRW;
      end
      S_CTRW: begin
        if (rdata_q[POT_W] && (dims_q != '0)) begin
          r2_d    = '0;
          sq_d    = '0;
          state_d = S_SQ;
        end else begin
          state_d = S_SC1;
          if (!last_cell) begin
            state_d = S_CTR;
            idx_d   = idx_q + ADDR_W'(1);
            if (32'(z_q) == SIZE_Z - 1) begin
              z_d = '0;
              if (32'(y_q) == SIZE_Y - 1) begin
                y_d = '0;
                x_d = x_q + XW'(1);
              end else begin
                y_d = y_q + YW'(1);
              end
            end else begin
              z_d = z_q + ZW'(1);
            end
          end
        end
      end
      S_SQ: begin
        r2_d = r2_q + R2_W'(sq_prod);
        sq_d = sq_q + 2'd1;
        if (sq_q == 2'd2) begin
          state_d = S_SQS;
        end
      end
      S_SQS: begin
        state_d = S_SQW;
      end
      S_SQW: begin
        if (sqrt_done) begin
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        d_d     = D_W'(r2_q) * D_W'(root);
        ax_d    = '0;
        state_d = S_NRD1;
      end
      S_NRD1: begin
        mem_raddr = idx_q + stride;
        state_d   = S_NRD2;
      end
      S_NRD2: begin
        pp_d      = {plus_ok & rdata_q[POT_W], rdata_q[POT_W-1:0]};
        mem_raddr = idx_q - stride;
        state_d   = S_NCHK;
      end
      S_NCHK: begin
        if (pp_q[POT_W] && minus_ok && rdata_q[POT_W] && (ra != '0)) begin
          diff_d  = $signed({pp_q[POT_W-1], pp_q[POT_W-1:0]}) -
                    $signed({rdata_q[POT_W-1], rdata_q[POT_W-1:0]});
          state_d = S_DVS;
        end else if (!last_axis) begin
          ax_d    = ax_q + 2'd1;
          state_d = S_NRD1;
        end else begin
          state_d = S_ACC;
          prod_d  = '0;
        end
      end
      S_DVS: begin
        state_d = S_DVW;
      end
      S_DVW: begin
        if (div_done) begin
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        prod_d  = diff_q * w;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d  = acc_q + ACC_W'(prod_q);
        prod_d = '0;
        if (!last_axis) begin
          ax_d    = ax_q + 2'd1;
          state_d = S_NRD1;
        end else begin
          // move to the next cell, or to scaling after the last one
          state_d = S_SC1;
          if (!last_cell) begin
            state_d = S_CTR;
            idx_d   = idx_q + ADDR_W'(1);
            if (32'(z_q) == SIZE_Z - 1) begin
              z_d = '0;
              if (32'(y_q) == SIZE_Y - 1) begin
                y_d = '0;
                x_d = x_q + XW'(1);
              end else begin
                y_d = y_q + YW'(1);
              end
            end else begin
              z_d = z_q + ZW'(1);
            end
          end
        end
      end
      S_SC1: begin
        plo_d   = ACC_W'(mag[31:0]) * ACC_W'(scale_q);
        state_d = S_SC2;
      end
      S_SC2: begin
        v_d     = (ACC_W + 1)'(ACC_W'(mag[ACC_W-1:32]) * ACC_W'(scale_q)) +
                  (((ACC_W + 1)'(plo_q) + (ACC_W + 1)'(33'h080000000)) >> 32);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (acc_q[ACC_W-1]) begin
            if ((v_q[ACC_W:OUT_W+1] != '0) || (v_cut > NEG_MAG)) begin
              out_d = NEG_MAG[OUT_W-1:0];
            end else begin
              out_d = OUT_W'(-v_cut);
            end
          end else begin
            if ((v_q[ACC_W:OUT_W+1] != '0) || (v_cut > POS_MAX)) begin
              out_d = POS_MAX[OUT_W-1:0];
            end else begin
              out_d = v_cut[OUT_W-1:0];
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      sq_q        <= '0;
      ax_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      sq_q        <= sq_d;
      ax_q        <= ax_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r2_q   <= r2_d;
    d_q    <= d_d;
    pp_q   <= pp_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    plo_q  <= plo_d;
    v_q    <= v_d;
    out_q  <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(65536);
      lead_x_q <= '0;
      lead_y_q <= '0;
      lead_z_q <= '0;
      dims_q   <= DIMS_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_LEAD_X: lead_x_q <= cfg_data_i[LEAD_W-1:0];
        REG_LEAD_Y: lead_y_q <= cfg_data_i[LEAD_W-1:0];
        REG_LEAD_Z: lead_z_q <= cfg_data_i[LEAD_W-1:0];
        REG_DIMS:   dims_q   <= cfg_data_i[DIMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // cell memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

endmodule

@@ bench/pseudo_ecg_lead_sum_top_tb.sv @@
`timescale 1ns / 100ps

module pseudo_ecg_lead_sum_top_tb;
  import pel_pkg::*;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;
  localparam longint ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN    = 64'sh8000_0000_0000_0000;
  localparam longint unsigned OUT_POS_MAX = 64'h7FFF_FFFF_FFFF;
  localparam longint unsigned OUT_NEG_MAG = 64'h8000_0000_0000;

  typedef struct {
    logic                    mode;
    logic [COORD_IN_W-1:0]   cx;
    logic [COORD_IN_W-1:0]   cy;
    logic [COORD_IN_W-1:0]   cz;
    logic signed [POT_W-1:0] pot;
    logic                    tis;
  } grid_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    mode_i = 1'b0;
  logic [COORD_IN_W-1:0]   cell_x_i = '0;
  logic [COORD_IN_W-1:0]   cell_y_i = '0;
  logic [COORD_IN_W-1:0]   cell_z_i = '0;
  logic signed [POT_W-1:0] potential_i = '0;
  logic                    tissue_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] ecg_value_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = REG_SCALE;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  pseudo_ecg_lead_sum_top u_top (.*);

  always #2 clk_i = ~clk_i;

  // shadow of the block: grid memory and registers
  shortint     pot_mem [CELLS];
  bit          tis_mem [CELLS];
  int unsigned gain;
  int          lead_pos [3];
  int unsigned axes;

  grid_word_t  word_q [$];
  logic [OUT_W-1:0] ecg_q [$];
  grid_word_t  cur_word;
  bit          word_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          err_count = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int cell_addr(int x, int y, int z);
    return (x * SIZE_Y + y) * SIZE_Z + z;
  endfunction

  function automatic bit tissue_at(int x, int y, int z);
    if (x < 0 || x >= SIZE_X || y < 0 || y >= SIZE_Y || z < 0 || z >= SIZE_Z)
      return 1'b0;
    return tis_mem[cell_addr(x, y, z)];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // offset over r cubed in Q.24, rounded to nearest
  function automatic longint axis_weight(longint ra, longint unsigned den);
    longint unsigned mag;
    if (ra == 0 || den == 0) return 0;
    mag = (ra < 0) ? -ra : ra;
    mag = ((mag << 40) + den / 2) / den;
    return (ra < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint acc_add(longint acc, longint term);
    if (term > 0 && acc > ACC_MAX - term) return ACC_MAX;
    if (term < 0 && acc < ACC_MIN - term) return ACC_MIN;
    return acc + term;
  endfunction

  // full grid walk, then gain and saturation
  function automatic logic [OUT_W-1:0] lead_sum();
    longint acc = 0;
    longint r [3];
    longint unsigned r2, den, m, v;
    int p [3];
    int lo [3];
    int hi [3];
    bit neg;
    for (int x = 0; x < SIZE_X; x++)
      for (int y = 0; y < SIZE_Y; y++)
        for (int z = 0; z < SIZE_Z; z++) begin
          if (!tissue_at(x, y, z)) continue;
          p = '{x, y, z};
          for (int a = 0; a < 3; a++) r[a] = longint'(p[a]) - longint'(lead_pos[a]);
          r2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
          den = r2 * int_sqrt(r2 << 32);
          for (int a = 0; a < 3; a++) begin
            if (axes < a + 1) continue;
            lo = p; hi = p;
            lo[a]--; hi[a]++;
            if (!tissue_at(hi[0], hi[1], hi[2]) || !tissue_at(lo[0], lo[1], lo[2])) continue;
            acc = acc_add(acc, (longint'(pot_mem[cell_addr(hi[0], hi[1], hi[2])]) -
                                longint'(pot_mem[cell_addr(lo[0], lo[1], lo[2])])) *
                               axis_weight(r[a], den));
          end
        end
    neg = acc < 0;
    m = neg ? (64'd0 - longint'(acc)) : acc;
    v = (m >> 32) * gain + (((m & 64'hFFFF_FFFF) * gain + 64'h8000_0000) >> 32);
    if (neg) begin
      if (v > OUT_NEG_MAG) v = OUT_NEG_MAG;
      v = 64'd0 - v;
    end else if (v > OUT_POS_MAX) begin
      v = OUT_POS_MAX;
    end
    return v[OUT_W-1:0];
  endfunction

  task automatic apply_word(input grid_word_t w);
    int a;
    if (w.mode == MODE_LOAD) begin
      a = cell_addr(w.cx, w.cy, w.cz);
      pot_mem[a] = w.pot;
      tis_mem[a] = w.tis;
    end else begin
      ecg_q.push_back(lead_sum());
    end
  endtask

  // input side: take accepted words into the shadow
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      apply_word(cur_word);
      word_taken = 1'b1;
    end
  end

  // input side: offer the next word
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      word_taken = 1'b0;
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word = word_q.pop_front();
        mode_i      <= cur_word.mode;
        cell_x_i    <= cur_word.cx;
        cell_y_i    <= cur_word.cy;
        cell_z_i    <= cur_word.cz;
        potential_i <= cur_word.pot;
        tissue_i    <= cur_word.tis;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: compare against the oldest expected value
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (ecg_q.size() == 0) begin
        report_mismatch($sformatf("unexpected ecg word %h", ecg_value_o));
      end else begin
        if (ecg_value_o !== ecg_q[0])
          report_mismatch($sformatf("ecg_value got %h want %h", ecg_value_o, ecg_q[0]));
        void'(ecg_q.pop_front());
      end
    end
  end

  // long receiver hold-off count
  always @(negedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(negedge clk_i) begin
    out_ready_i <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_SCALE:  gain = val;
      REG_LEAD_X: lead_pos[0] = val;
      REG_LEAD_Y: lead_pos[1] = val;
      REG_LEAD_Z: lead_pos[2] = val;
      REG_DIMS:   axes = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned sc, input int unsigned lx,
                          input int unsigned ly, input int unsigned lz,
                          input int unsigned dm);
    write_reg(REG_SCALE, sc);
    write_reg(REG_LEAD_X, lx);
    write_reg(REG_LEAD_Y, ly);
    write_reg(REG_LEAD_Z, lz);
    write_reg(REG_DIMS, dm);
  endtask

  task automatic push_load(input int x, input int y, input int z, input int p, input bit t);
    grid_word_t w;
    w.mode = MODE_LOAD;
    w.cx = COORD_IN_W'(x); w.cy = COORD_IN_W'(y); w.cz = COORD_IN_W'(z);
    w.pot = POT_W'(p); w.tis = t;
    word_q.push_back(w);
  endtask

  task automatic push_compute();
    grid_word_t w;
    w.mode = MODE_COMPUTE;
    w.cx = COORD_IN_W'($urandom); w.cy = COORD_IN_W'($urandom);
    w.cz = COORD_IN_W'($urandom);
    w.pot = POT_W'($urandom); w.tis = 1'($urandom);
    word_q.push_back(w);
  endtask

  // sender pause until every expected value has come back
  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || ecg_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mostly a compact tissue block, some scattered cells, a few grid walks
  task automatic push_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 7)
        push_compute();
      else if (sel < 60)
        push_load($urandom_range(9, 5), $urandom_range(9, 5), $urandom_range(9, 5),
                  $urandom, 1'b1);
      else
        push_load($urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom, $urandom_range(99) < 15);
    end
  endtask

  function automatic int unsigned pick_lead();
    case ($urandom_range(3))
      0: return 0;
      1: return 10000;
      2: return $urandom_range(10000);
      default: return $urandom_range(20);
    endcase
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(3))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return 65536;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int idle_tab [5][2];
    idle_tab = '{'{0, 0}, '{56, 0}, '{0, 56}, '{7, 7}, '{0, 0}};
    foreach (pot_mem[i]) begin
      pot_mem[i] = 0;
      tis_mem[i] = 1'b0;
    end
    gain = 65536;
    lead_pos = '{0, 0, 0};
    axes = 3;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty map, lead cell, extremes, each axis, edge of the grid
    push_compute();
    push_load(0, 0, 0, -32768, 1'b1);
    push_load(1, 0, 0, 0, 1'b1);
    push_load(2, 0, 0, 32767, 1'b1);
    push_load(1, 1, 0, 1, 1'b1);
    push_load(1, 2, 0, -1, 1'b1);
    push_load(1, 1, 1, 32767, 1'b1);
    push_load(1, 1, 2, -32768, 1'b1);
    push_load(13, 15, 15, -32768, 1'b1);
    push_load(14, 15, 15, 100, 1'b1);
    push_load(15, 15, 15, 32767, 1'b1);
    push_compute();
    push_load(15, 15, 15, 32767, 1'b0);
    push_compute();
    drain();
    set_regs(32'hFFFF_FFFF, 1, 1, 1, 0);
    push_compute();
    drain();
    set_regs(32'hFFFF_FFFF, 10000, 10000, 10000, 1);
    push_compute();
    drain();
    set_regs(0, 1, 1, 0, 2);
    push_compute();
    drain();
    set_regs(12345, 1, 0, 0, 3);
    push_compute();
    drain();

    // random phases with varying registers and idling
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(pick_gain(), pick_lead(), pick_lead(), pick_lead(), $urandom_range(3));
      send_idle_pct  = idle_tab[ph][0];
      recv_stall_pct = idle_tab[ph][1];
      // receiver holds off while words keep coming, so the block backs up
      if (ph == 4) hold_cycles = 150000;
      push_random(120);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (err_count == 0)
      $display("pseudo_ecg_lead_sum_top_tb: done, clean");
    else
      $display("pseudo_ecg_lead_sum_top_tb: done, errors");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("pseudo_ecg_lead_sum_top_tb: done, errors");
    $finish;
  end

endmodule

@@ pseudo_ecg_lead_sum_top.f @@
hdl/pel_pkg.sv
hdl/pel_sqrt.sv
hdl/pel_div.sv
hdl/pseudo_ecg_lead_sum_top.sv
bench/pseudo_ecg_lead_sum_top_tb.sv
